// ===== sv/symbol_projection_to_range_unit_macros.svh =====
// assertion macros for the symbol projection unit
// used by symbol_projection_to_range_unit.sv; no other dependencies
`ifndef SYMBOL_PROJECTION_TO_RANGE_UNIT_MACROS_SVH
`define SYMBOL_PROJECTION_TO_RANGE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPRJ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprj assertion failed");
// next-cycle implication
`define SPRJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprj assertion failed");
`else
`define SPRJ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPRJ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sprj_pkg.sv =====
// shared types and constants of the symbol projection unit
// no dependencies
`default_nettype none
package sprj_pkg;

  localparam int SYM_W        = 64;
  localparam int POS_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int POS_WIDTH_DEF = 32;

  // splitmix64 finalizer
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;

  // fraction divider: quotient bits resolved per pipeline stage
  localparam int FRAC_BITS  = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // reset values
  localparam logic        MAP_MODE_RST    = 1'b0;
  localparam logic [63:0] SOURCE_LOW_RST  = 64'h0;
  localparam logic [63:0] SOURCE_HIGH_RST = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] RANGE_START_RST = 32'hFFF8_0000;
  localparam logic [31:0] RANGE_END_RST   = 32'h0008_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_MODE    = 3'd0,
    REG_SOURCE_LOW  = 3'd1,
    REG_SOURCE_HIGH = 3'd2,
    REG_RANGE_START = 3'd3,
    REG_RANGE_END   = 3'd4
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== sv/sprj_if.sv =====
// valid/ready channels of the symbol projection unit
// depends on sprj_pkg
`default_nettype none
interface sprj_sym_if
  import sprj_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

interface sprj_pos_if
  import sprj_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface
`default_nettype wire

// ===== sv/symbol_projection_to_range_unit.sv =====
// symbol projection unit: maps a 64-bit symbol to a signed Q16.16 point
// depends on sprj_pkg, sprj_if.sv and symbol_projection_to_range_unit_macros.svh
//
// usage
//   sym_in carries one symbol per transaction, pos_out one position per
//   transaction, both valid/ready. cfg_we/cfg_idx/cfg_data write the five
//   registers (mode, source low/high, range start/end); write only while idle.
//   the block is a 21-stage pipeline; one transaction per cycle is taken and
//   delivered continuously while pos_out does not stall. the depth is set by
//   the input capture stage, the fraction divider, which resolves two quotient
//   bits per stage over 16 stages, the finalizer multiplies that run beside it,
//   and the select, scaling multiply, rounding and add stages after it.
//   when pos_out stalls the whole pipeline holds and sym_in.ready drops in the
//   same cycle; sym_in.ready is high whenever the output register is empty or
//   being taken. reset (rst, synchronous) empties the pipeline and restores
//   the register reset values.
`default_nettype none
`include "symbol_projection_to_range_unit_macros.svh"
module symbol_projection_to_range_unit
  import sprj_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sprj_sym_if.sink              sym_in,
  sprj_pos_if.source            pos_out
);

  localparam int POS_BITS = (POS_WIDTH < POS_W) ? POS_WIDTH : POS_W;
  localparam int LAST     = DIV_STAGES + 4;

  // configuration registers
  logic                map_mode;
  logic [63:0]         source_low;
  logic [63:0]         source_high;
  logic [POS_BITS-1:0] range_start;
  logic [POS_BITS-1:0] range_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode    <= MAP_MODE_RST;
      source_low  <= SOURCE_LOW_RST;
      source_high <= SOURCE_HIGH_RST;
      range_start <= RANGE_START_RST[POS_BITS-1:0];
      range_end   <= RANGE_END_RST[POS_BITS-1:0];
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MAP_MODE:    map_mode    <= cfg_data[0];
        REG_SOURCE_LOW:  source_low  <= cfg_data;
        REG_SOURCE_HIGH: source_high <= cfg_data;
        REG_RANGE_START: range_start <= cfg_data[POS_BITS-1:0];
        REG_RANGE_END:   range_end   <= cfg_data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // interval span, sign-extended to 33 bits
  logic [32:0] lo_x;
  logic [32:0] hi_x;
  logic [32:0] diff;
  logic [32:0] mag_full;
  logic        diff_neg;
  logic [31:0] mag;

  assign lo_x     = {{(33-POS_BITS){range_start[POS_BITS-1]}}, range_start};
  assign hi_x     = {{(33-POS_BITS){range_end[POS_BITS-1]}}, range_end};
  assign diff     = hi_x - lo_x;
  assign diff_neg = diff[32];
  assign mag_full = diff_neg ? (33'd0 - diff) : diff;
  assign mag      = mag_full[31:0];

  // valid chain and global stall
  logic [LAST:0] vld;
  logic          en;

  assign en           = !vld[LAST] || pos_out.ready;
  assign sym_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], sym_in.valid};
    end
  end

  // stage 0: input capture, first xor-shift, affine offset and span
  logic [63:0] hx0;
  logic [63:0] rem [0:DIV_STAGES];
  logic [63:0] den [0:DIV_STAGES];
  logic [31:0] quo [0:DIV_STAGES];
  logic        zer [0:DIV_STAGES];
  logic        one [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      hx0    <= sym_in.symbol ^ (sym_in.symbol >> MIX_SH1);
      rem[0] <= sym_in.symbol - source_low;
      den[0] <= source_high - source_low;
      quo[0] <= '0;
      zer[0] <= (source_high <= source_low) || (sym_in.symbol <= source_low);
      one[0] <= sym_in.symbol >= source_high;
    end
  end

  // fraction divider stages, restoring, DIV_STEPS quotient bits each
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [63:0] r_c;
    logic [31:0] q_c;
    logic [64:0] t;

    always_comb begin
      r_c = rem[k-1];
      q_c = quo[k-1];
      t   = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        t   = {r_c, 1'b0};
        q_c = {q_c[30:0], 1'b0};
        if (t >= {1'b0, den[k-1]}) begin
          t      = t - {1'b0, den[k-1]};
          q_c[0] = 1'b1;
        end
        r_c = t[63:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= r_c;
        quo[k] <= q_c;
        den[k] <= den[k-1];
        zer[k] <= zer[k-1];
        one[k] <= one[k-1];
      end
    end
  end

  // finalizer: each 64-bit multiply as partial products, then a sum stage
  logic [63:0] a_ll;
  logic [31:0] a_hl;
  logic [31:0] a_lh;
  logic [63:0] y_c;
  logic [63:0] hy;
  logic [63:0] b_ll;
  logic [31:0] b_hl;
  logic [31:0] b_lh;
  logic [63:0] z_c;
  logic [63:0] zz_c;
  logic [31:0] hu [4:DIV_STAGES];

  assign y_c  = a_ll + {a_hl + a_lh, 32'h0};
  assign z_c  = b_ll + {b_hl + b_lh, 32'h0};
  assign zz_c = z_c ^ (z_c >> MIX_SH3);

  always_ff @(posedge clk) begin
    if (en) begin
      a_ll  <= hx0[31:0] * MIX_C1[31:0];
      a_hl  <= hx0[63:32] * MIX_C1[31:0];
      a_lh  <= hx0[31:0] * MIX_C1[63:32];
      hy    <= y_c ^ (y_c >> MIX_SH2);
      b_ll  <= hy[31:0] * MIX_C2[31:0];
      b_hl  <= hy[63:32] * MIX_C2[31:0];
      b_lh  <= hy[31:0] * MIX_C2[63:32];
      hu[4] <= zz_c[63:32];
    end
  end

  // hash fraction rides alongside the divider
  for (genvar k = 5; k <= DIV_STAGES; k++) begin : g_hcarry
    always_ff @(posedge clk) begin
      if (en) begin
        hu[k] <= hu[k-1];
      end
    end
  end

  // unit fraction select, 1.32
  logic [32:0] u_q;

  always_ff @(posedge clk) begin
    if (en) begin
      if (map_mode) begin
        u_q <= {1'b0, hu[DIV_STAGES]};
      end else if (zer[DIV_STAGES]) begin
        u_q <= '0;
      end else if (one[DIV_STAGES]) begin
        u_q <= ONE_Q32;
      end else begin
        u_q <= {1'b0, quo[DIV_STAGES]};
      end
    end
  end

  // scale by span magnitude
  logic [63:0] prod_q;

  always_ff @(posedge clk) begin
    if (en) begin
      if (u_q[32]) begin
        prod_q <= {mag, 32'h0};
      end else begin
        prod_q <= u_q[31:0] * mag;
      end
    end
  end

  // round toward minus infinity on a falling span
  logic [64:0] rs_c;
  logic [32:0] m_q;

  assign rs_c = {1'b0, prod_q} + (diff_neg ? 65'h0_FFFF_FFFF : 65'h0);

  always_ff @(posedge clk) begin
    if (en) begin
      m_q <= rs_c[64:32];
    end
  end

  // offset from range start, output register
  logic [33:0]      pos_c;
  logic [POS_W-1:0] position_q;

  assign pos_c = diff_neg ? ({lo_x[32], lo_x} - {1'b0, m_q})
                          : ({lo_x[32], lo_x} + {1'b0, m_q});

  always_ff @(posedge clk) begin
    if (en) begin
      position_q <= pos_c[POS_W-1:0];
    end
  end

  assign pos_out.valid    = vld[LAST];
  assign pos_out.position = position_q;

  // checks
  `SPRJ_ASSERT_NEXT(a_count, clk, rst, sym_in.valid && en && !(vld[LAST] && pos_out.ready), $countones(vld) == $past($countones(vld)) + 1)
  `SPRJ_ASSERT_IMPL(a_unit, clk, rst, vld[LAST-3], u_q <= ONE_Q32)
  `SPRJ_ASSERT_NEXT(a_hold, clk, rst, !en, $stable(vld))

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench of the symbol projection unit: directed and random symbols, all modes
// depends on sprj_pkg, sprj_if.sv and symbol_projection_to_range_unit.sv
`default_nettype none
module tb;
  import sprj_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sprj_sym_if sym_ch ();
  sprj_pos_if pos_ch ();

  symbol_projection_to_range_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .sym_in(sym_ch.sink), .pos_out(pos_ch.source)
  );

  // shadow copy of the configuration registers
  logic        mode_q;
  logic [63:0] src_lo_q;
  logic [63:0] src_hi_q;
  logic [31:0] rng_lo_q;
  logic [31:0] rng_hi_q;

  logic signed [31:0] pos_expected_q[$];
  int errors;
  int sent_cnt;
  int checked_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // time limit
  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [63:0] splitmix_hash(input logic [63:0] x);
    logic [63:0] h;
    h = x ^ (x >> 30);
    h = h * 64'hbf58476d1ce4e5b9;
    h = h ^ (h >> 27);
    h = h * 64'h94d049bb133111eb;
    h = h ^ (h >> 31);
    return h;
  endfunction

  // unit fraction in 1.32, exactly 2^32 means one
  function automatic logic [32:0] unit_fraction(input logic [63:0] sym);
    logic [64:0] rem;
    logic [32:0] q;
    logic [63:0] span;
    logic [63:0] h;
    if (mode_q) begin
      h = splitmix_hash(sym);
      return {1'b0, h[63:32]};
    end
    if (src_hi_q <= src_lo_q || sym <= src_lo_q) return 33'd0;
    if (sym >= src_hi_q) return ONE_Q32;
    span = src_hi_q - src_lo_q;
    rem = {1'b0, sym - src_lo_q};
    q = 33'd0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= {1'b0, span}) begin
        rem = rem - {1'b0, span};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [31:0] projected_position(input logic [63:0] sym);
    logic signed [63:0] lo, hi, diff, off;
    logic [63:0] mag;
    logic [97:0] prod;
    lo = 64'(signed'(rng_lo_q));
    hi = 64'(signed'(rng_hi_q));
    diff = hi - lo;
    mag = diff < 0 ? 64'(-diff) : 64'(diff);
    prod = 98'(unit_fraction(sym)) * 98'(mag);
    if (diff >= 0) off = 64'(prod >> 32);
    else off = -64'((prod + 98'(32'hFFFF_FFFF)) >> 32);
    return 32'(lo + off);
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_MAP_MODE:    mode_q = data[0];
      REG_SOURCE_LOW:  src_lo_q = data;
      REG_SOURCE_HIGH: src_hi_q = data;
      REG_RANGE_START: rng_lo_q = data[31:0];
      REG_RANGE_END:   rng_hi_q = data[31:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic m, input logic [63:0] slo, input logic [63:0] shi,
                           input logic [31:0] rlo, input logic [31:0] rhi);
    write_reg(REG_MAP_MODE, {63'd0, m});
    write_reg(REG_SOURCE_LOW, slo);
    write_reg(REG_SOURCE_HIGH, shi);
    write_reg(REG_RANGE_START, {32'd0, rlo});
    write_reg(REG_RANGE_END, {32'd0, rhi});
    cfg_we <= 1'b0;
  endtask

  // send one symbol, with random idle cycles ahead of it; valid stays up
  // until the next send or drain lowers it
  task automatic send_symbol(input logic [63:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid <= 1'b1;
    sym_ch.symbol <= sym;
    pos_expected_q.push_back(projected_position(sym));
    sent_cnt++;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    sym_ch.valid <= 1'b0;
    while (pos_expected_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // symbol near a configured source bound, fully random, near the source midpoint or inside the source span
  function automatic logic [63:0] rand_symbol();
    logic [63:0] span;
    span = src_hi_q - src_lo_q + 64'd1;
    case ($urandom_range(5))
      0: return src_lo_q + 64'($urandom_range(3)) - 64'd1;
      1: return src_hi_q + 64'($urandom_range(3)) - 64'd1;
      2: return rand64();
      3: return src_lo_q + ((src_hi_q - src_lo_q) >> 1) + 64'($urandom);
      default: begin
        if (span == 64'd0) return rand64();
        return src_lo_q + (rand64() % span);
      end
    endcase
  endfunction

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pos_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      pos_ch.ready <= 1'b0;
    end else begin
      pos_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each position transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pos_ch.valid && pos_ch.ready) begin
      if (pos_expected_q.size() == 0) begin
        $error("position: unexpected transaction, actual %0d", pos_ch.position);
        errors++;
      end else begin
        logic signed [31:0] want;
        want = pos_expected_q.pop_front();
        checked_cnt++;
        if (pos_ch.position !== want) begin
          $error("position: expected %0d actual %0d", want, pos_ch.position);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    mode_q = MAP_MODE_RST; src_lo_q = SOURCE_LOW_RST; src_hi_q = SOURCE_HIGH_RST;
    rng_lo_q = RANGE_START_RST; rng_hi_q = RANGE_END_RST;
    send_symbol(64'd0);
    send_symbol(64'd1);
    send_symbol(64'h7FFF_FFFF);
    send_symbol(64'hFFFF_FFFF);
    send_symbol('1);
    drain();
  endtask

  task automatic test_affine_edges();
    configure(1'b0, 64'd1000, 64'd2000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_symbol(64'd0); send_symbol(64'd999); send_symbol(64'd1000);
    send_symbol(64'd1001); send_symbol(64'd1500); send_symbol(64'd1999);
    send_symbol(64'd2000); send_symbol('1);
    drain();
    // inverted output interval
    configure(1'b0, 64'd0, '1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_symbol(64'd1); send_symbol(64'h8000_0000_0000_0000); send_symbol('1 - 64'd1);
    drain();
    // zero and inverted source span, equal ends
    configure(1'b0, 64'd5, 64'd5, 32'h0001_0000, 32'h0002_0000);
    send_symbol(64'd4); send_symbol(64'd9);
    drain();
    configure(1'b0, '1, 64'd0, 32'h0003_0000, 32'h0003_0000);
    send_symbol(64'd7); send_symbol('1);
    drain();
  endtask

  task automatic test_hash_edges();
    configure(1'b1, 64'd0, 64'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_symbol(64'd0); send_symbol('1); send_symbol(64'h5555_5555_AAAA_AAAA);
    drain();
  endtask

  // random settings and symbols under one idling pattern
  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (k % 30 == 0) begin
        logic [63:0] a, b;
        drain();
        a = rand64() >> $urandom_range(63);
        b = a + (rand64() >> $urandom_range(63));
        if ($urandom_range(9) == 0) b = a - 64'($urandom_range(2));
        configure($urandom_range(2) == 0, a, b, $urandom, $urandom);
      end
      send_symbol(rand_symbol());
    end
    drain();
  endtask

  // block fills up behind a long receiver hold-off
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 80;
    for (int k = 0; k < 40; k++) send_symbol(rand_symbol());
    drain();
  endtask

  initial begin
    errors = 0; sent_cnt = 0; checked_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0; cfg_idx <= REG_MAP_MODE; cfg_data <= '0;
    sym_ch.valid <= 1'b0; sym_ch.symbol <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_affine_edges();
    test_hash_edges();
    test_random(120, 0, 0);
    test_random(120, 76, 0);
    test_random(120, 0, 76);
    test_random(120, 29, 29);
    test_backpressure();
    $display("tb: %0d symbols sent, %0d positions checked", sent_cnt, checked_cnt);
    $display("tb: affine and hash modes, span and interval edges, stalls and hold-off");
    if (errors == 0 && pos_expected_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
